// ===== rtl/rmq_pkg.sv =====
// Shared constants and widths for the rotation matrix to quaternion block.
// No dependencies; every other file imports this package.
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam int IN_W  = 16;
	localparam int QW_W  = 15;
	localparam int QV_W  = 16;

	localparam int T_W   = IN_W + 3;
	localparam int D_W   = IN_W + 1;
	localparam int MAG_W = IN_W + 1;

	localparam int SQ_X_W   = ((T_W - 1 + FRAC_BITS - 2 + 1) / 2) * 2;
	localparam int R_W      = SQ_X_W / 2;
	localparam int REM_W    = R_W + 2;
	localparam int SQ_STEPS = R_W;

	localparam int QB       = FRAC_BITS + 1;
	localparam int NUM_W    = MAG_W + FRAC_BITS + 1;
	localparam int DEN_W    = R_W + 2;
	localparam int DSH_W    = DEN_W + QB;
	localparam int DIV_W    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int DIV_LAT  = QB + 1;

	localparam int LAT      = 1 + SQ_STEPS + DIV_LAT + 1;

endpackage

// ===== rtl/rmq_if.sv =====
// Valid/ready channel interfaces for the matrix input and quaternion output.
// Depends on rmq_pkg for field widths.
interface rmq_mat_if import rmq_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic        [QW_W-1:0] qw;
	logic signed [QV_W-1:0] qx, qy, qz;
	logic                   status;
	modport source (output valid, qw, qx, qy, qz, status, input ready);
	modport sink (input valid, qw, qx, qy, qz, status, output ready);
endinterface

// ===== rtl/rmq_div_pipe.sv =====
// Pipelined restoring divider: round(mag * ONE / (4 w)), clamped to ONE, signed.
// One quotient bit per stage; depends on rmq_pkg.
module rmq_div_pipe import rmq_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [MAG_W-1:0]        mag,
	input  logic                    neg,
	input  logic [R_W-1:0]          w,
	output logic signed [QV_W-1:0]  q
);

	logic [DIV_W-1:0] rem_s [QB+1];
	logic [DIV_W-1:0] den_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic             neg_s [QB+1];
	logic             ovf_s [QB+1];

	logic [DIV_W-1:0] num0;
	logic [DIV_W-1:0] den0;

	assign num0 = (DIV_W'(mag) << FRAC_BITS) + (DIV_W'(w) << 1);
	assign den0 = DIV_W'(w) << 2;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num0;
			den_s[0] <= den0;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= num0 >= (den0 << QB);
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		localparam int B = QB - 1 - i;
		logic [DIV_W-1:0] sh;
		logic             take;
		assign sh   = den_s[i] << B;
		assign take = rem_s[i] >= sh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - sh : rem_s[i];
				quo_s[i+1] <= quo_s[i] | (QB'(take) << B);
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	logic [QB-1:0] qm;
	always_comb begin
		if (ovf_s[QB] || quo_s[QB] > QB'(ONE)) begin
			qm = QB'(ONE);
		end else begin
			qm = quo_s[QB];
		end
	end

	assign q = neg_s[QB] ? -$signed(QV_W'(qm)) : $signed(QV_W'(qm));

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix (Q2.14) to unit quaternion, trace form.
// Depends on rmq_pkg, rmq_if and rmq_div_pipe.
//
//  channel | dir | fields                                   | handshake
//  mat     | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22      | valid/ready
//  quat    | out | qw qx qy qz status                       | valid/ready
//
// One matrix per cycle while the output is not held; the stages are one sum
// stage, one square-root bit per stage (15), divider setup plus one quotient bit
// per stage (16), and the output register.
// Reset clears the valid bits only; no state survives an item.
// A held output stalls the whole pipeline; nothing is lost or repeated.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);

	logic [LAT-1:0] v_q;
	logic           en;

	assign en        = !v_q[LAT-1] || quat.ready;
	assign mat.ready = en;
	assign quat.valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], mat.valid};
		end
	end

	logic signed [T_W-1:0] t_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= T_W'(ONE) + T_W'(mat.m00) + T_W'(mat.m11) + T_W'(mat.m22);
			dx_s1 <= D_W'(mat.m21) - D_W'(mat.m12);
			dy_s1 <= D_W'(mat.m02) - D_W'(mat.m20);
			dz_s1 <= D_W'(mat.m10) - D_W'(mat.m01);
		end
	end

	logic [SQ_X_W-1:0]     sq_x_s   [SQ_STEPS+1];
	logic [REM_W-1:0]      sq_rem_s [SQ_STEPS+1];
	logic [R_W-1:0]        sq_root_s[SQ_STEPS+1];
	logic                  sq_deg_s [SQ_STEPS+1];
	logic signed [D_W-1:0] sq_dx_s  [SQ_STEPS+1];
	logic signed [D_W-1:0] sq_dy_s  [SQ_STEPS+1];
	logic signed [D_W-1:0] sq_dz_s  [SQ_STEPS+1];

	assign sq_x_s[0]    = SQ_X_W'(t_s1[T_W-2:0]) << (FRAC_BITS - 2);
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_deg_s[0]  = t_s1[T_W-1] || (t_s1 == '0);
	assign sq_dx_s[0]   = dx_s1;
	assign sq_dy_s[0]   = dy_s1;
	assign sq_dz_s[0]   = dz_s1;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;
		logic             take;
		assign r2    = {sq_rem_s[i][REM_W-3:0], sq_x_s[i][SQ_X_W-1 -: 2]};
		assign trial = {sq_root_s[i], 2'b01};
		assign take  = r2 >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_x_s[i+1]    <= sq_x_s[i] << 2;
				sq_rem_s[i+1]  <= take ? r2 - trial : r2;
				sq_root_s[i+1] <= {sq_root_s[i][R_W-2:0], take};
				sq_deg_s[i+1]  <= sq_deg_s[i];
				sq_dx_s[i+1]   <= sq_dx_s[i];
				sq_dy_s[i+1]   <= sq_dy_s[i];
				sq_dz_s[i+1]   <= sq_dz_s[i];
			end
		end
	end

	logic [R_W-1:0]        root;
	logic signed [D_W-1:0] dv [3];
	logic signed [QV_W-1:0] qv [3];

	assign root  = sq_root_s[SQ_STEPS];
	assign dv[0] = sq_dx_s[SQ_STEPS];
	assign dv[1] = sq_dy_s[SQ_STEPS];
	assign dv[2] = sq_dz_s[SQ_STEPS];

	for (genvar c = 0; c < 3; c++) begin : g_div
		rmq_div_pipe u_div (
			.clk (clk),
			.en  (en),
			.mag (MAG_W'(dv[c][D_W-1] ? -dv[c] : dv[c])),
			.neg (dv[c][D_W-1]),
			.w   (root),
			.q   (qv[c])
		);
	end

	logic [QW_W-1:0] wo_s  [DIV_LAT+1];
	logic            deg_s [DIV_LAT+1];

	assign wo_s[0]  = (root > R_W'(ONE)) ? QW_W'(ONE) : QW_W'(root);
	assign deg_s[0] = sq_deg_s[SQ_STEPS];

	for (genvar i = 0; i < DIV_LAT; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				wo_s[i+1]  <= wo_s[i];
				deg_s[i+1] <= deg_s[i];
			end
		end
	end

	logic [QW_W-1:0]        qw_q;
	logic signed [QV_W-1:0] qx_q, qy_q, qz_q;
	logic                   status_q;

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= deg_s[DIV_LAT];
			qw_q     <= deg_s[DIV_LAT] ? '0 : wo_s[DIV_LAT];
			qx_q     <= deg_s[DIV_LAT] ? '0 : qv[0];
			qy_q     <= deg_s[DIV_LAT] ? '0 : qv[1];
			qz_q     <= deg_s[DIV_LAT] ? '0 : qv[2];
		end
	end

	assign quat.qw     = qw_q;
	assign quat.qx     = qx_q;
	assign quat.qy     = qy_q;
	assign quat.qz     = qz_q;
	assign quat.status = status_q;

endmodule

// ===== rtl/rmq_chk.sv =====
// Port-level checks on the quaternion output of the top level, and its bind.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
module rmq_chk import rmq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [QW_W-1:0]        qw,
	input logic signed [QV_W-1:0] qx,
	input logic signed [QV_W-1:0] qy,
	input logic signed [QV_W-1:0] qz,
	input logic                   status
);

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> qw == '0 && qx == '0 && qy == '0 && qz == '0)
		else $error("degenerate result not all zero");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> qw >= QW_W'(8) && qw <= QW_W'(ONE))
		else $error("w out of range");

	a_v_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> qx <= QV_W'(ONE) && qx >= -QV_W'(ONE) &&
			qy <= QV_W'(ONE) && qy >= -QV_W'(ONE) &&
			qz <= QV_W'(ONE) && qz >= -QV_W'(ONE))
		else $error("vector part not saturated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(qw) && $stable(qx) &&
			$stable(qy) && $stable(qz) && $stable(status))
		else $error("stalled transfer changed");

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (quat.valid),
	.out_ready (quat.ready),
	.qw        (quat.qw),
	.qx        (quat.qx),
	.qy        (quat.qy),
	.qz        (quat.qz),
	.status    (quat.status)
);
